@@ hdl/ejm_pkg.sv @@
// ----------------------------------------------------------------------------
// ejm_pkg
// Shared types, command codes and indices for the energy and derivatives block.
// ----------------------------------------------------------------------------
package ejm_pkg;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] idx;
  } cmd_t;

  typedef struct packed {
    logic e_zero;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic [30:0] rest_mass;
    logic [30:0] tolerance_sq;
    logic [30:0] var_px;
    logic [30:0] var_py;
    logic [30:0] var_pz;
  } cfg_t;

  // Register indices on the configuration port.
  localparam logic [2:0] RI_MASS = 3'd0;
  localparam logic [2:0] RI_TOL  = 3'd1;
  localparam logic [2:0] RI_VX   = 3'd2;
  localparam logic [2:0] RI_VY   = 3'd3;
  localparam logic [2:0] RI_VZ   = 3'd4;

  // Products formed on the shared multiplier.
  localparam logic [3:0] MI_X2  = 4'd0;
  localparam logic [3:0] MI_Y2  = 4'd1;
  localparam logic [3:0] MI_Z2  = 4'd2;
  localparam logic [3:0] MI_M2  = 4'd3;
  localparam logic [3:0] MI_XY  = 4'd4;
  localparam logic [3:0] MI_XZ  = 4'd5;
  localparam logic [3:0] MI_YZ  = 4'd6;
  localparam logic [3:0] MI_DX2 = 4'd7;
  localparam logic [3:0] MI_DY2 = 4'd8;
  localparam logic [3:0] MI_DZ2 = 4'd9;
  localparam logic [3:0] MI_TX  = 4'd10;
  localparam logic [3:0] MI_TY  = 4'd11;
  localparam logic [3:0] MI_TZ  = 4'd12;
  localparam logic [3:0] MI_EE  = 4'd13;
  localparam logic [3:0] MI_CLO = 4'd14;
  localparam logic [3:0] MI_CHI = 4'd15;
  localparam int         PROD_N = 13;

  // Quotients formed on the shared divider.
  localparam logic [3:0] DI_GX  = 4'd0;
  localparam logic [3:0] DI_GY  = 4'd1;
  localparam logic [3:0] DI_GZ  = 4'd2;
  localparam logic [3:0] DI_HXX = 4'd3;
  localparam logic [3:0] DI_HXY = 4'd4;
  localparam logic [3:0] DI_HXZ = 4'd5;
  localparam logic [3:0] DI_HYY = 4'd6;
  localparam logic [3:0] DI_HYZ = 4'd7;
  localparam logic [3:0] DI_HZZ = 4'd8;
  localparam int         RES_N  = 9;

  localparam logic [5:0] GRAD_STEPS = 6'd61;
  localparam logic [5:0] HESS_STEPS = 6'd31;
  localparam logic [5:0] SQRT_STEPS = 6'd31;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  function automatic logic [32:0] abs33(input logic [32:0] v);
    abs33 = v[32] ? (33'd0 - v) : v;
  endfunction

endpackage

@@ hdl/ejm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ejm_ctrl
// Sequencer that steps the datapath through products, root and divisions.
// ----------------------------------------------------------------------------
module ejm_ctrl
  import ejm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL    = 9'b000000010,
    S_SQI    = 9'b000000100,
    S_SQRT   = 9'b000001000,
    S_CUBE   = 9'b000010000,
    S_DLOAD  = 9'b000100000,
    S_DSTEP  = 9'b001000000,
    S_DSTORE = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [3:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    cmd.op    = OP_NONE;
    cmd.idx   = idx_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          idx_nxt   = MI_X2;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op  = OP_MUL;
        idx_nxt = idx_r + 4'd1;
        if (idx_r == MI_TZ) begin
          state_nxt = S_SQI;
        end
      end
      S_SQI: begin
        cmd.op    = OP_SQRT_INIT;
        cnt_nxt   = SQRT_STEPS;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op  = OP_SQRT_STEP;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          idx_nxt   = MI_EE;
          state_nxt = S_CUBE;
        end
      end
      S_CUBE: begin
        if (idx_r == MI_EE && sts.e_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op = OP_MUL;
          if (idx_r == MI_CHI) begin
            idx_nxt   = DI_GX;
            state_nxt = S_DLOAD;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
      end
      S_DLOAD: begin
        cmd.op    = OP_DIV_LOAD;
        cnt_nxt   = (idx_r < DI_HXX) ? GRAD_STEPS : HESS_STEPS;
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          state_nxt = S_DSTORE;
        end
      end
      S_DSTORE: begin
        cmd.op = OP_DIV_STORE;
        if (idx_r == DI_HZZ) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + 4'd1;
          state_nxt = S_DLOAD;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.op    = OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

@@ hdl/ejm_dpath.sv @@
// ----------------------------------------------------------------------------
// ejm_dpath
// Shared multiplier, bitwise square root, shift-subtract divider and result
// register.
// ----------------------------------------------------------------------------
module ejm_dpath
  import ejm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  cfg_t               cfg,
  input  logic signed [31:0] in_new_px,
  input  logic signed [31:0] in_new_py,
  input  logic signed [31:0] in_new_pz,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_changed,
  output logic        [32:0] out_energy,
  output logic signed [31:0] out_de_dpx,
  output logic signed [31:0] out_de_dpy,
  output logic signed [31:0] out_de_dpz,
  output logic signed [31:0] out_h_xx,
  output logic signed [31:0] out_h_xy,
  output logic signed [31:0] out_h_xz,
  output logic signed [31:0] out_h_yy,
  output logic signed [31:0] out_h_yz,
  output logic signed [31:0] out_h_zz,
  output logic        [1:0]  out_status
);

  logic [31:0] last_px_r, last_py_r, last_pz_r;
  logic [31:0] ax_r, ay_r, az_r, dx_r, dy_r, dz_r;
  logic        sx_r, sy_r, sz_r;
  logic [63:0] prod_r [PROD_N];
  logic [65:0] ee_r;
  logic [98:0] cube_r;
  logic [63:0] sq_n_r, sq_res_r, sq_bit_r;
  logic [98:0] rem_r;
  logic [63:0] sh_r;
  logic [31:0] q_r;
  logic        neg_r, pre_sat_r, sat_r;
  logic [31:0] res_r [RES_N];

  logic        out_valid_r, out_changed_r;
  logic [32:0] out_energy_r;
  logic [31:0] out_res_r [RES_N];
  logic [1:0]  out_status_r;

  logic [32:0] e;
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  logic [63:0] e2, num, sq_t;
  logic [31:0] gmag;
  logic        neg_sel;
  logic [99:0] rs, dvsr, rs_sub;
  logic        rs_ge;
  logic [31:0] lim, hmag, gval, hval;
  logic [32:0] dxs, dys, dzs;
  logic [32:0] axs, ays, azs;

  assign e = sq_res_r[32:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.idx)
      MI_X2:  begin mul_a = {1'b0, ax_r}; mul_b = {1'b0, ax_r}; end
      MI_Y2:  begin mul_a = {1'b0, ay_r}; mul_b = {1'b0, ay_r}; end
      MI_Z2:  begin mul_a = {1'b0, az_r}; mul_b = {1'b0, az_r}; end
      MI_M2:  begin mul_a = {2'b0, cfg.rest_mass}; mul_b = {2'b0, cfg.rest_mass}; end
      MI_XY:  begin mul_a = {1'b0, ax_r}; mul_b = {1'b0, ay_r}; end
      MI_XZ:  begin mul_a = {1'b0, ax_r}; mul_b = {1'b0, az_r}; end
      MI_YZ:  begin mul_a = {1'b0, ay_r}; mul_b = {1'b0, az_r}; end
      MI_DX2: begin mul_a = {1'b0, dx_r}; mul_b = {1'b0, dx_r}; end
      MI_DY2: begin mul_a = {1'b0, dy_r}; mul_b = {1'b0, dy_r}; end
      MI_DZ2: begin mul_a = {1'b0, dz_r}; mul_b = {1'b0, dz_r}; end
      MI_TX:  begin mul_a = {2'b0, cfg.tolerance_sq}; mul_b = {2'b0, cfg.var_px}; end
      MI_TY:  begin mul_a = {2'b0, cfg.tolerance_sq}; mul_b = {2'b0, cfg.var_py}; end
      MI_TZ:  begin mul_a = {2'b0, cfg.tolerance_sq}; mul_b = {2'b0, cfg.var_pz}; end
      MI_EE:  begin mul_a = e; mul_b = e; end
      MI_CLO: begin mul_a = ee_r[32:0]; mul_b = e; end
      MI_CHI: begin mul_a = ee_r[65:33]; mul_b = e; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign e2   = prod_r[MI_X2] + prod_r[MI_Y2] + prod_r[MI_Z2] + prod_r[MI_M2];
  assign sq_t = sq_res_r + sq_bit_r;

  always_comb begin
    num     = '0;
    gmag    = ax_r;
    neg_sel = 1'b0;
    unique case (cmd.idx)
      DI_GX:  begin gmag = ax_r; neg_sel = sx_r; end
      DI_GY:  begin gmag = ay_r; neg_sel = sy_r; end
      DI_GZ:  begin gmag = az_r; neg_sel = sz_r; end
      DI_HXX: num = prod_r[MI_Y2] + prod_r[MI_Z2] + prod_r[MI_M2];
      DI_HXY: begin num = prod_r[MI_XY]; neg_sel = (sx_r == sy_r); end
      DI_HXZ: begin num = prod_r[MI_XZ]; neg_sel = (sx_r == sz_r); end
      DI_HYY: num = prod_r[MI_X2] + prod_r[MI_Z2] + prod_r[MI_M2];
      DI_HYZ: begin num = prod_r[MI_YZ]; neg_sel = (sy_r == sz_r); end
      DI_HZZ: num = prod_r[MI_X2] + prod_r[MI_Y2] + prod_r[MI_M2];
      default: begin num = '0; neg_sel = 1'b0; end
    endcase
  end

  assign rs     = {rem_r, sh_r[63]};
  assign dvsr   = (cmd.idx < DI_HXX) ? {67'd0, e} : {1'b0, cube_r};
  assign rs_ge  = (rs >= dvsr);
  assign rs_sub = rs - dvsr;

  assign lim  = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign hmag = (pre_sat_r || (q_r > lim)) ? lim : q_r;
  assign gval = neg_r ? (32'd0 - q_r) : q_r;
  assign hval = neg_r ? (32'd0 - hmag) : hmag;

  assign axs = abs33({in_new_px[31], in_new_px});
  assign ays = abs33({in_new_py[31], in_new_py});
  assign azs = abs33({in_new_pz[31], in_new_pz});

  assign dxs = abs33({in_new_px[31], in_new_px} - {last_px_r[31], last_px_r});
  assign dys = abs33({in_new_py[31], in_new_py} - {last_py_r[31], last_py_r});
  assign dzs = abs33({in_new_pz[31], in_new_pz} - {last_pz_r[31], last_pz_r});

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        ax_r <= axs[31:0];
        ay_r <= ays[31:0];
        az_r <= azs[31:0];
        sx_r <= in_new_px[31];
        sy_r <= in_new_py[31];
        sz_r <= in_new_pz[31];
        dx_r <= dxs[31:0];
        dy_r <= dys[31:0];
        dz_r <= dzs[31:0];
      end
      OP_MUL: begin
        unique case (cmd.idx)
          MI_EE:   ee_r <= mul_p;
          MI_CLO:  cube_r <= {33'd0, mul_p};
          MI_CHI:  cube_r <= cube_r + {mul_p, 33'd0};
          default: prod_r[cmd.idx] <= mul_p[63:0];
        endcase
      end
      OP_SQRT_INIT: begin
        sq_n_r   <= e2;
        sq_res_r <= '0;
        sq_bit_r <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT_STEP: begin
        if (sq_n_r >= sq_t) begin
          sq_n_r   <= sq_n_r - sq_t;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      OP_DIV_LOAD: begin
        neg_r <= neg_sel;
        q_r   <= '0;
        if (cmd.idx < DI_HXX) begin
          rem_r     <= '0;
          sh_r      <= {gmag, 32'd0};
          pre_sat_r <= 1'b0;
        end else begin
          rem_r     <= {27'd0, num, 8'd0};
          sh_r      <= '0;
          pre_sat_r <= ({27'd0, num, 8'd0} >= cube_r);
        end
      end
      OP_DIV_STEP: begin
        rem_r <= rs_ge ? rs_sub[98:0] : rs[98:0];
        q_r   <= {q_r[30:0], rs_ge};
        sh_r  <= {sh_r[62:0], 1'b0};
      end
      OP_DIV_STORE: begin
        res_r[cmd.idx] <= (cmd.idx < DI_HXX) ? gval : hval;
      end
      OP_FINISH: begin
        out_changed_r <= (prod_r[MI_DX2] > prod_r[MI_TX]) ||
                         (prod_r[MI_DY2] > prod_r[MI_TY]) ||
                         (prod_r[MI_DZ2] > prod_r[MI_TZ]);
        for (int i = 0; i < RES_N; i++) begin
          out_res_r[i] <= sts.e_zero ? 32'd0 : res_r[i];
        end
        out_energy_r <= e;
        out_status_r <= sts.e_zero ? ST_ZERO : (sat_r ? ST_SAT : ST_OK);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_px_r   <= '0;
      last_py_r   <= '0;
      last_pz_r   <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_LOAD) begin
        last_px_r <= in_new_px;
        last_py_r <= in_new_py;
        last_pz_r <= in_new_pz;
        sat_r     <= 1'b0;
      end else if (cmd.op == OP_DIV_STORE && cmd.idx >= DI_HXX &&
                   (pre_sat_r || (q_r > lim))) begin
        sat_r <= 1'b1;
      end
      if (cmd.op == OP_FINISH) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts = '{e_zero: (e == 33'd0), out_busy: out_valid_r & ~out_ready};

  assign out_valid   = out_valid_r;
  assign out_changed = out_changed_r;
  assign out_energy  = out_energy_r;
  assign out_de_dpx  = out_res_r[DI_GX];
  assign out_de_dpy  = out_res_r[DI_GY];
  assign out_de_dpz  = out_res_r[DI_GZ];
  assign out_h_xx    = out_res_r[DI_HXX];
  assign out_h_xy    = out_res_r[DI_HXY];
  assign out_h_xz    = out_res_r[DI_HXZ];
  assign out_h_yy    = out_res_r[DI_HYY];
  assign out_h_yz    = out_res_r[DI_HYZ];
  assign out_h_zz    = out_res_r[DI_HZZ];
  assign out_status  = out_status_r;

endmodule

@@ hdl/energy_and_derivatives_from_momentum.sv @@
// ----------------------------------------------------------------------------
// energy_and_derivatives_from_momentum
// Relativistic energy, gradient and Hessian from a momentum request.
// ----------------------------------------------------------------------------
// One request is processed at a time. A request with zero energy skips the
// divisions; otherwise the shared shift-subtract divider produces one
// quotient bit per cycle for three 62-bit gradient quotients and six 32-bit
// Hessian quotients, after 13 products on the shared multiplier and a 32-step
// square root. A finished result waits in the output register while the next
// request is taken.
module energy_and_derivatives_from_momentum
  import ejm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_new_px,
  input  logic signed [31:0] in_new_py,
  input  logic signed [31:0] in_new_pz,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_changed,
  output logic        [32:0] out_energy,
  output logic signed [31:0] out_de_dpx,
  output logic signed [31:0] out_de_dpy,
  output logic signed [31:0] out_de_dpz,
  output logic signed [31:0] out_h_xx,
  output logic signed [31:0] out_h_xy,
  output logic signed [31:0] out_h_xz,
  output logic signed [31:0] out_h_yy,
  output logic signed [31:0] out_h_yz,
  output logic signed [31:0] out_h_zz,
  output logic        [1:0]  out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [4:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        RI_MASS: cfg_r.rest_mass    <= pwdata[30:0];
        RI_TOL:  cfg_r.tolerance_sq <= pwdata[30:0];
        RI_VX:   cfg_r.var_px       <= pwdata[30:0];
        RI_VY:   cfg_r.var_py       <= pwdata[30:0];
        RI_VZ:   cfg_r.var_pz       <= pwdata[30:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RI_MASS: prdata = {1'b0, cfg_r.rest_mass};
      RI_TOL:  prdata = {1'b0, cfg_r.tolerance_sq};
      RI_VX:   prdata = {1'b0, cfg_r.var_px};
      RI_VY:   prdata = {1'b0, cfg_r.var_py};
      RI_VZ:   prdata = {1'b0, cfg_r.var_pz};
      default: prdata = '0;
    endcase
  end

  ejm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ejm_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg         (cfg_r),
    .in_new_px   (in_new_px),
    .in_new_py   (in_new_py),
    .in_new_pz   (in_new_pz),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_changed (out_changed),
    .out_energy  (out_energy),
    .out_de_dpx  (out_de_dpx),
    .out_de_dpy  (out_de_dpy),
    .out_de_dpz  (out_de_dpz),
    .out_h_xx    (out_h_xx),
    .out_h_xy    (out_h_xy),
    .out_h_xz    (out_h_xz),
    .out_h_yy    (out_h_yy),
    .out_h_yz    (out_h_yz),
    .out_h_zz    (out_h_zz),
    .out_status  (out_status)
  );

endmodule

@@ hdl/ejm_chk.sv @@
// ----------------------------------------------------------------------------
// ejm_chk
// Port-level checks on the energy and derivatives block.
// ----------------------------------------------------------------------------
module ejm_chk
  import ejm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [32:0] out_energy,
  input logic [31:0] out_de_dpx,
  input logic [31:0] out_h_xx,
  input logic [1:0]  out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_energy))
    else $error("result changed while stalled");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  a_zero_energy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ZERO |->
      out_energy == 33'd0 && out_de_dpx == 32'd0 && out_h_xx == 32'd0)
    else $error("zero-energy result carries data");

  a_energy_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK || out_status == ST_SAT) |->
      out_energy != 33'd0)
    else $error("zero energy without its status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

endmodule

bind energy_and_derivatives_from_momentum ejm_chk u_ejm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_energy (out_energy),
  .out_de_dpx (out_de_dpx),
  .out_h_xx   (out_h_xx),
  .out_status (out_status)
);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the momentum to energy, gradient and Hessian block.
// Requests go in over a valid/ready channel and each one is predicted in the
// bench. Every result is checked field by field in arrival order. A short
// table of directed requests comes first, then random requests under several
// register settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import ejm_pkg::*;

  localparam logic [2:0] RI_SPARE = 3'd7;

  typedef struct packed {
    logic        changed;
    logic [32:0] energy;
    logic [31:0] gx, gy, gz;
    logic [31:0] hxx, hxy, hxz, hyy, hyz, hzz;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic [31:0] px, py, pz;
    logic        typed;
    result_t     want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_new_px = '0, in_new_py = '0, in_new_pz = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_changed;
  logic [32:0] out_energy;
  logic [31:0] out_de_dpx, out_de_dpy, out_de_dpz;
  logic [31:0] out_h_xx, out_h_xy, out_h_xz, out_h_yy, out_h_yz, out_h_zz;
  logic [1:0] out_status;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  energy_and_derivatives_from_momentum u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [30:0] mass, tol_sq, var_x, var_y, var_z;
  logic signed [31:0] prev_px, prev_py, prev_pz;
  result_t expected_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] magnitude(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic exceeds(input logic [31:0] nv, input logic [31:0] ov,
                                   input logic [30:0] vr);
    logic signed [32:0] d;
    logic [63:0] ad;
    d = {nv[31], nv} - {ov[31], ov};
    ad = d[32] ? 64'(-d) : 64'(d);
    return ad * ad > 64'(tol_sq) * 64'(vr);
  endfunction

  function automatic logic [31:0] slope(input logic [31:0] p, input logic [63:0] e);
    logic [63:0] q;
    q = (64'(magnitude(p)) << 30) / e;
    return p[31] ? 32'(-q) : 32'(q);
  endfunction

  function automatic logic [31:0] curvature(input logic [63:0] num, input logic neg,
                                            input logic [63:0] e, inout logic sat);
    logic [127:0] q, lim;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    q = {num, 40'd0} / (128'(e) * 128'(e) * 128'(e));
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    return neg ? 32'(-q) : 32'(q);
  endfunction

  function automatic result_t compute_energy_terms(input logic [31:0] px,
                                                   input logic [31:0] py,
                                                   input logic [31:0] pz);
    result_t r;
    logic [63:0] ax, ay, az, x2, y2, z2, m2, e2, e;
    logic sat;
    r = '0;
    sat = 1'b0;
    ax = 64'(magnitude(px));
    ay = 64'(magnitude(py));
    az = 64'(magnitude(pz));
    x2 = ax * ax;
    y2 = ay * ay;
    z2 = az * az;
    m2 = 64'(mass) * 64'(mass);
    e2 = x2 + y2 + z2 + m2;
    r.changed = exceeds(px, prev_px, var_x) || exceeds(py, prev_py, var_y) ||
                exceeds(pz, prev_pz, var_z);
    prev_px = px;
    prev_py = py;
    prev_pz = pz;
    e = isqrt(e2);
    if (e == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    r.energy = 33'(e);
    r.gx = slope(px, e);
    r.gy = slope(py, e);
    r.gz = slope(pz, e);
    r.hxx = curvature(y2 + z2 + m2, 1'b0, e, sat);
    r.hxy = curvature(ax * ay, px[31] == py[31], e, sat);
    r.hxz = curvature(ax * az, px[31] == pz[31], e, sat);
    r.hyy = curvature(x2 + z2 + m2, 1'b0, e, sat);
    r.hyz = curvature(ay * az, py[31] == pz[31], e, sat);
    r.hzz = curvature(x2 + y2 + m2, 1'b0, e, sat);
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  task automatic send_request(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz, input logic typed,
                              input result_t want);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_new_px = px;
    in_new_py = py;
    in_new_pz = pz;
    do @(posedge clk); while (!in_ready);
    r = compute_energy_terms(px, py, pz);
    expected_results.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      RI_MASS: mass = val[30:0];
      RI_TOL:  tol_sq = val[30:0];
      RI_VX:   var_x = val[30:0];
      RI_VY:   var_y = val[30:0];
      RI_VZ:   var_z = val[30:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [32:0] want,
                             input logic [32:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $realtime, name, want, got);
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    result_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, energy %0h", $realtime, out_energy);
      end else begin
        w = expected_results.pop_front();
        check_field("changed", w.changed, out_changed);
        check_field("energy", w.energy, out_energy);
        check_field("de_dpx", w.gx, out_de_dpx);
        check_field("de_dpy", w.gy, out_de_dpy);
        check_field("de_dpz", w.gz, out_de_dpz);
        check_field("h_xx", w.hxx, out_h_xx);
        check_field("h_xy", w.hxy, out_h_xy);
        check_field("h_xz", w.hxz, out_h_xz);
        check_field("h_yy", w.hyy, out_h_yy);
        check_field("h_yz", w.hyz, out_h_yz);
        check_field("h_zz", w.hzz, out_h_zz);
        check_field("status", w.status, out_status);
      end
    end
  end

  function automatic logic [31:0] pick_component(input logic [31:0] last);
    logic [31:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4, 5: v = 32'($signed(16'($urandom)));
      6, 7: v = last + 32'($signed(20'($urandom)) >>> $urandom_range(19));
      8: v = '0;
      default: begin
        case ($urandom_range(4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'd1;
          3: v = 32'hFFFF_FFFF;
          default: v = 32'd0;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_setting(input int kind);
    case (kind)
      0: return 32'd0;
      1: return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF;
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  row_t dir_rows[18];

  initial begin
    logic [31:0] cx, cy, cz;
    mass = '0;
    tol_sq = '0;
    var_x = '0;
    var_y = '0;
    var_z = '0;
    prev_px = '0;
    prev_py = '0;
    prev_pz = '0;
    dir_rows = '{
      '{32'h0, 32'h0, 32'h0, 1'b1, '{1'b0, 33'd0, 32'd0, 32'd0, 32'd0, 32'd0,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0, ST_ZERO}},
      '{32'h0, 32'h0, 32'h0, 1'b1, '{1'b0, 33'd0, 32'd0, 32'd0, 32'd0, 32'd0,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0, ST_ZERO}},
      '{32'h0100_0000, 32'h0, 32'h0, 1'b1, '{1'b1, 33'h0100_0000, 32'h4000_0000,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'h0001_0000, ST_OK}},
      '{32'h0, 32'hFF00_0000, 32'h0, 1'b0, '0},
      '{32'h0, 32'h0, 32'h0100_0000, 1'b0, '0},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0, '0},
      '{32'h1, 32'h0, 32'h0, 1'b0, '0},
      '{32'h1, 32'h1, 32'h1, 1'b0, '0},
      '{32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 1'b0, '0},
      '{32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 1'b0, '0},
      '{32'h0000_4000, 32'hFFFF_C000, 32'h0000_0100, 1'b0, '0},
      '{32'h0100_0000, 32'h0200_0000, 32'hFD00_0000, 1'b0, '0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
      '{32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0000, 1'b0, '0},
      '{32'h0, 32'h0, 32'h8000_0000, 1'b0, '0},
      '{32'h1234_5678, 32'hEDCB_A988, 32'h0F0F_0F0F, 1'b0, '0}
    };
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_request(dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz,
                   dir_rows[i].typed, dir_rows[i].want);
    wait_drained();
    write_reg(RI_SPARE, 32'hFFFF_FFFF);
    write_reg(RI_MASS, 32'hFFFF_FFFF);
    send_request(32'h0, 32'h0, 32'h0, 1'b0, '0);
    send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0);
    wait_drained();

    for (int seg = 0; seg < 6; seg++) begin
      send_idle_pct = (seg < 2) ? 34 : (seg < 4) ? 72 : 0;
      recv_idle_pct = (seg < 2) ? 72 : (seg < 4) ? 34 : 0;
      wait_drained();
      write_reg(RI_MASS, pick_setting((seg == 0) ? 1 : (seg == 3) ? 0 : 2));
      write_reg(RI_TOL, pick_setting(seg % 3));
      write_reg(RI_VX, pick_setting((seg + 1) % 3));
      write_reg(RI_VY, pick_setting(seg % 3));
      write_reg(RI_VZ, pick_setting((seg + 2) % 3));
      for (int n = 0; n < 158; n++) begin
        if ($urandom_range(49) == 0) wait_drained();
        cx = pick_component(prev_px);
        cy = pick_component(prev_py);
        cz = pick_component(prev_pz);
        send_request(cx, cy, cz, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (500) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
